/* hdl/assert_macros.svh */
// Assertion macros for the RTL files, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* hdl/cmdi_pkg.sv */
// Package: mesh geometry, widths, opcodes, memory request type and saturation helper.
`timescale 1ns / 1ps
package cmdi_pkg;

  localparam int MESH_SIDE  = 32;
  localparam int SIDE_W     = $clog2(MESH_SIDE);
  localparam int MESH_CELLS = MESH_SIDE * MESH_SIDE * MESH_SIDE;
  localparam int CELL_W     = $clog2(MESH_CELLS);
  localparam int VAL_W      = 48;
  localparam int ACC_W      = 52;

  localparam logic signed [ACC_W-1:0] VAL_MAX = 52'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] VAL_MIN = -52'sh0_8000_0000_0000;

  typedef enum logic [1:0] {
    OP_DEPOSIT     = 2'd0,
    OP_INTERPOLATE = 2'd1,
    OP_WRITE_CELL  = 2'd2,
    OP_READ_CELL   = 2'd3
  } mesh_op_e;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] addr;
    logic [VAL_W-1:0]  wdata;
  } mesh_req_t;

  function automatic logic [VAL_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > VAL_MAX) begin
      r = VAL_MAX;
    end else if (v < VAL_MIN) begin
      r = VAL_MIN;
    end else begin
      r = v;
    end
    return r[VAL_W-1:0];
  endfunction

endpackage

/* hdl/cmdi_mesh_ram.sv */
// Single-port mesh memory, read-first, with registered read data.
`timescale 1ns / 1ps
module cmdi_mesh_ram
  import cmdi_pkg::*;
(
  input  logic             clk_i,
  input  mesh_req_t        req_i,
  output logic [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem [MESH_CELLS];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.addr];
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/cic_mesh_deposit_interpolate_unit.sv */
// Top level: cloud-in-cell deposit / interpolate sequencer over the mesh memory.
//
//  channel  | dir | handshake            | contents
//  s_axis   | in  | tvalid/tready        | tuser opcode, tdata position/mass/cell request
//  m_axis   | out | tvalid/tready        | tdata result_value
//  cfg      | in  | cfg_we_i             | cfg_wdata_i = cell_scale
//
// A request is taken only in S_IDLE; deposit and interpolate make eight corner accesses
// in turn through the single mesh port, with a shared multiplier chain, while write cell
// and read cell access one cell; the next request waits until the sequencer is back in S_IDLE.
// After reset a clearing pass zeroes all MESH_CELLS entries, tready low.
// A finished result sits in the output register; the next request is taken meanwhile,
// and the sequencer stalls only when a second result is ready before the first is taken.
`timescale 1ns / 1ps
module cic_mesh_deposit_interpolate_unit
  import cmdi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,   // cell_scale
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // pos_x, pos_y, pos_z, mass, cell_index, cell_value
  input  logic [1:0]   s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata   // result_value
);

`include "assert_macros.svh"

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_AXIS  = 4'd3;
  localparam logic [3:0] S_W1    = 4'd4;
  localparam logic [3:0] S_W2    = 4'd5;
  localparam logic [3:0] S_M1    = 4'd6;
  localparam logic [3:0] S_M2    = 4'd7;
  localparam logic [3:0] S_M3    = 4'd8;
  localparam logic [3:0] S_CELL  = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  logic [3:0]        state_q, state_d;
  logic [CELL_W-1:0] clr_q;
  logic [31:0]       scale_q;
  logic [1:0]        axis_q;
  logic [2:0]        corner_q;
  logic              m_valid_q;
  logic [VAL_W-1:0]  m_data_q;

  logic [1:0]               op_q;
  logic [2:0][31:0]         pos_q;
  logic [31:0]              mass_q;
  logic [14:0]              ci_q;
  logic [VAL_W-1:0]         cv_q;
  logic [63:0]              p_q;
  logic [2:0][SIDE_W-1:0]   cell_q;
  logic [2:0][16:0]         d_q;
  logic [33:0]              wxy_q;
  logic [32:0]              w_q;
  logic signed [VAL_W-1:0]  v_q;
  logic [64:0]              dep_q;
  logic signed [65:0]       a_q;
  logic signed [63:0]       b_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [VAL_W-1:0]         res_q;

  mesh_req_t         ram_req;
  logic [VAL_W-1:0]  ram_rdata;

  logic              s_fire;
  logic              out_free;
  logic              in_range;
  logic [SIDE_W-1:0] xc, yc, zc;
  logic [16:0]       wx, wy, wz;
  logic [CELL_W-1:0] idx;
  logic [33:0]       wxy;
  logic [50:0]       wfull;
  logic signed [ACC_W-1:0] dep_sum;
  logic signed [65:0] term;
  logic signed [ACC_W-1:0] acc_nx;
  logic [SIDE_W-1:0] c_clamp;
  logic [16:0]       d_clamp;

  function automatic logic [SIDE_W-1:0] nxt(input logic [SIDE_W-1:0] c);
    return (c == SIDE_W'(MESH_SIDE - 1)) ? '0 : c + 1'b1;
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign in_range      = (32'(ci_q) < 32'(MESH_CELLS));
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // corner selection: bit 2 picks x neighbor, bit 1 y, bit 0 z
  assign xc = corner_q[2] ? nxt(cell_q[0]) : cell_q[0];
  assign yc = corner_q[1] ? nxt(cell_q[1]) : cell_q[1];
  assign zc = corner_q[0] ? nxt(cell_q[2]) : cell_q[2];
  assign wx = corner_q[2] ? d_q[0] : ONE_Q16 - d_q[0];
  assign wy = corner_q[1] ? d_q[1] : ONE_Q16 - d_q[1];
  assign wz = corner_q[0] ? d_q[2] : ONE_Q16 - d_q[2];
  assign idx = CELL_W'(xc) * CELL_W'(MESH_SIDE * MESH_SIDE)
             + CELL_W'(yc) * CELL_W'(MESH_SIDE) + CELL_W'(zc);

  assign wxy     = 34'(wx) * 34'(wy);
  assign wfull   = 51'(wxy_q) * 51'(wz);
  assign dep_sum = ACC_W'(v_q) + $signed({20'd0, dep_q[63:32]});
  assign term    = (a_q + (66'(b_q) >>> 16)) >>> 16;
  assign acc_nx  = acc_q + ACC_W'(term);

  // out-of-mesh positions clamp to the last cell with full weight on the neighbor
  assign c_clamp = (p_q[63:32] >= 32'(MESH_SIDE)) ? SIDE_W'(MESH_SIDE - 1)
                                                  : SIDE_W'(p_q[63:32]);
  assign d_clamp = (p_q[63:32] >= 32'(MESH_SIDE)) ? ONE_Q16 : {1'b0, p_q[31:16]};

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.addr  = idx;
    ram_req.wdata = '0;
    case (state_q)
      S_CLEAR: begin
        ram_req.we   = 1'b1;
        ram_req.addr = clr_q;
      end
      S_CELL: begin
        ram_req.we    = (op_q == OP_WRITE_CELL) && in_range;
        ram_req.addr  = CELL_W'(ci_q);
        ram_req.wdata = cv_q;
      end
      S_M2: begin
        ram_req.we    = (op_q == OP_DEPOSIT);
        ram_req.wdata = sat48(dep_sum);
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == CELL_W'(MESH_CELLS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (s_fire) begin
          state_d = (s_axis_tuser == OP_DEPOSIT || s_axis_tuser == OP_INTERPOLATE) ?
                    S_MUL : S_CELL;
        end
      end
      S_MUL:  state_d = S_AXIS;
      S_AXIS: state_d = (axis_q == 2'd2) ? S_W1 : S_MUL;
      S_W1:   state_d = S_W2;
      S_W2:   state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2: begin
        if (op_q == OP_INTERPOLATE) begin
          state_d = S_M3;
        end else begin
          state_d = (corner_q == 3'd7) ? S_IDLE : S_W1;
        end
      end
      S_M3:   state_d = (corner_q == 3'd7) ? S_OUT : S_W1;
      S_CELL: begin
        if (op_q == OP_WRITE_CELL) begin
          state_d = S_IDLE;
        end else begin
          state_d = in_range ? S_RD : S_OUT;
        end
      end
      S_RD:   state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      scale_q   <= 32'd65536;
      axis_q    <= '0;
      corner_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (s_fire) begin
        axis_q <= '0;
      end else if (state_q == S_AXIS) begin
        axis_q <= axis_q + 1'b1;
      end
      if (state_q == S_AXIS) begin
        corner_q <= '0;
      end else if ((state_q == S_M2 && op_q != OP_INTERPOLATE) || state_q == S_M3) begin
        corner_q <= corner_q + 1'b1;
      end
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q     <= s_axis_tuser;
      pos_q[0] <= s_axis_tdata[31:0];
      pos_q[1] <= s_axis_tdata[63:32];
      pos_q[2] <= s_axis_tdata[95:64];
      mass_q   <= s_axis_tdata[127:96];
      ci_q     <= s_axis_tdata[142:128];
      cv_q     <= s_axis_tdata[190:143];
    end
    case (state_q)
      S_MUL: p_q <= 64'(pos_q[axis_q]) * 64'(scale_q);
      S_AXIS: begin
        cell_q[axis_q] <= c_clamp;
        d_q[axis_q]    <= d_clamp;
        acc_q          <= '0;
      end
      S_W1: wxy_q <= wxy;
      S_W2: begin
        w_q <= wfull[48:16];
        v_q <= $signed(ram_rdata);
      end
      S_M1: begin
        dep_q <= 65'(mass_q) * 65'(w_q);
        a_q   <= 66'(v_q) * 66'($signed({1'b0, w_q[32:16]}));
      end
      S_M2: b_q <= 64'(v_q) * 64'($signed({1'b0, w_q[15:0]}));
      S_M3: begin
        acc_q <= acc_nx;
        res_q <= sat48(acc_nx);
      end
      S_CELL: res_q <= '0;
      S_RD:   res_q <= ram_rdata;
      default: begin
      end
    endcase
    if (state_q == S_OUT && out_free) begin
      m_data_q <= res_q;
    end
  end

  cmdi_mesh_ram u_mesh (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  `ASSERT_NEVER(a_no_req_in_clear, (state_q == S_CLEAR) && s_axis_tready, "request taken during clear")
  `ASSERT_PROP(a_we_states, ram_req.we |-> (state_q == S_CLEAR || state_q == S_M2 || state_q == S_CELL), "mesh write outside write states")
  `ASSERT_PROP(a_corner_start, (state_q == S_W1 && $past(state_q) == S_AXIS) |-> (corner_q == 3'd0), "corner walk not starting at zero")
  `ASSERT_PROP(a_out_load, (state_q == S_OUT && !out_free) |=> (state_q == S_OUT), "result dropped while output busy")

endmodule
